// ----- hdl/mt19937_generator_assert.svh -----
// Assertion macros used by the generator sequencer (mtg_ctrl).
`ifndef MT19937_GENERATOR_ASSERT_SVH
`define MT19937_GENERATOR_ASSERT_SVH
// antecedent holds, consequent holds in the same cycle
`define MTG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// antecedent holds, consequent holds in the next cycle
`define MTG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- hdl/mtg_pkg.sv -----
// Constants, types and tempering function of the MT19937 generator.
package mtg_pkg;
   localparam int STATE_WORDS  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int KEY_DEPTH_DEFAULT = 624;
   localparam int TAW = 10;

   localparam logic [31:0] SEED_MULT   = 32'd1812433253;
   localparam logic [31:0] MIX1_MULT   = 32'd1664525;
   localparam logic [31:0] MIX2_MULT   = 32'd1566083941;
   localparam logic [31:0] ARRAY_SEED  = 32'd19650218;
   localparam logic [31:0] HIGH_BIT    = 32'h8000_0000;
   localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;

   localparam logic [1:0] OP_SEED = 2'd0;
   localparam logic [1:0] OP_KEY  = 2'd1;
   localparam logic [1:0] OP_NEXT = 2'd2;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_FILL_MUL = 11'b000_0000_0010,
      ST_FILL_WR  = 11'b000_0000_0100,
      ST_MIX_RD   = 11'b000_0000_1000,
      ST_MIX_WR   = 11'b000_0001_0000,
      ST_MIX_WRAP = 11'b000_0010_0000,
      ST_MIX_FIN  = 11'b000_0100_0000,
      ST_NXT_A    = 11'b000_1000_0000,
      ST_NXT_B    = 11'b001_0000_0000,
      ST_NXT_C    = 11'b010_0000_0000,
      ST_NXT_D    = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic seed_val;
      logic seed_key;
      logic key_wr;
      logic fill_mul;
      logic fill_wr;
      logic mix_rd;
      logic mix_wr;
      logic wrap_wr;
      logic final_wr;
      logic nxt_a;
      logic nxt_b;
      logic nxt_c;
      logic nxt_d;
      logic noseed;
   } cmd_type;

   typedef struct packed {
      logic seeded;
      logic fill_last;
      logic mix_keys;
      logic i_last;
      logic k_last;
      logic pass2;
      logic mix_done;
   } status_type;

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & 32'h9d2c_5680);
      y = y ^ ((y << 15) & 32'hefc6_0000);
      y = y ^ (y >> 18);
      return y;
   endfunction
endpackage

// ----- hdl/mtg_ram.sv -----
// Generic RAM: one write port, one read port with registered data.
module mtg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- hdl/mtg_ctrl.sv -----
// Sequencer for seeding, key mixing and word generation.
module mtg_ctrl
   import mtg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] op,
   input  logic       last_key,
   input  status_type stat,
   output logic       busy,
   output cmd_type    cmd
);
`include "mt19937_generator_assert.svh"

   state_type state_ff, state_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_SEED: begin
                     cmd.seed_val = 1'b1;
                     state_in     = ST_FILL_MUL;
                  end
                  OP_KEY: begin
                     cmd.key_wr = 1'b1;
                     if (last_key) begin
                        cmd.seed_key = 1'b1;
                        state_in     = ST_FILL_MUL;
                     end
                  end
                  OP_NEXT: begin
                     if (stat.seeded) begin
                        state_in = ST_NXT_A;
                     end else begin
                        cmd.noseed = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL_MUL: begin
            cmd.fill_mul = 1'b1;
            state_in     = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            cmd.fill_wr = 1'b1;
            if (stat.fill_last) begin
               state_in = stat.mix_keys ? ST_MIX_RD : ST_IDLE;
            end else begin
               state_in = ST_FILL_MUL;
            end
         end
         ST_MIX_RD: begin
            cmd.mix_rd = 1'b1;
            state_in   = ST_MIX_WR;
         end
         ST_MIX_WR: begin
            cmd.mix_wr = 1'b1;
            if (stat.i_last) begin
               state_in = ST_MIX_WRAP;
            end else if (stat.k_last && stat.pass2) begin
               state_in = ST_MIX_FIN;
            end else begin
               state_in = ST_MIX_RD;
            end
         end
         ST_MIX_WRAP: begin
            cmd.wrap_wr = 1'b1;
            state_in    = stat.mix_done ? ST_MIX_FIN : ST_MIX_RD;
         end
         ST_MIX_FIN: begin
            cmd.final_wr = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_NXT_A: begin
            cmd.nxt_a = 1'b1;
            state_in  = ST_NXT_B;
         end
         ST_NXT_B: begin
            cmd.nxt_b = 1'b1;
            state_in  = ST_NXT_C;
         end
         ST_NXT_C: begin
            cmd.nxt_c = 1'b1;
            state_in  = ST_NXT_D;
         end
         ST_NXT_D: begin
            cmd.nxt_d = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `MTG_ASSERT_NOW(a_noseed_only_unseeded, cmd.noseed, !stat.seeded, "unseeded reply while seeded")
   `MTG_ASSERT_NEXT(a_next_starts_read, accept && op == OP_NEXT && stat.seeded,
      state_ff == ST_NXT_A, "next item did not start the table read")
   `MTG_ASSERT_NEXT(a_word_then_idle, state_ff == ST_NXT_D, state_ff == ST_IDLE,
      "word generation did not return to idle")
   `MTG_ASSERT_NOW(a_mix_only_keys, state_ff == ST_MIX_RD, stat.mix_keys,
      "key mixing without a key array")
endmodule

// ----- hdl/mtg_datapath.sv -----
// Table, key store, counters and arithmetic of the generator.
module mtg_datapath
   import mtg_pkg::*;
#(
   parameter int KEY_DEPTH = KEY_DEPTH_DEFAULT,
   localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1,
   localparam int KCW = $clog2(KEY_DEPTH + 1),
   localparam int KMAX = (KEY_DEPTH > STATE_WORDS) ? KEY_DEPTH : STATE_WORDS,
   localparam int KW = $clog2(KMAX + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] value,
   input  cmd_type     cmd,
   output status_type  stat,
   output logic        rsp_valid,
   output logic [31:0] rsp_random_word,
   output logic        rsp_not_seeded
);
   logic [31:0]    prev_ff, prod_ff, cur_ff, nxt_ff;
   logic [TAW-1:0] idx_ff, ptr_ff;
   logic [KAW-1:0] j_ff;
   logic [KW-1:0]  k_ff;
   logic [KCW-1:0] len_ff, count_ff;
   logic           pass2_ff, done_ff, keys_ff, seeded_ff, valid_ff;
   logic [31:0]    word_ff;
   logic           flag_ff;

   logic           t_we;
   logic [TAW-1:0] t_waddr, t_raddr;
   logic [31:0]    t_wdata, t_rdata, k_rdata;
   logic           key_full, k_we;

   logic [31:0]    fill_word, mix_base, mix_word, twist_word, mult_src;
   logic [31:0]    y;
   logic [TAW-1:0] ptr_nx, ptr_far;
   logic [KCW-1:0] j_inc;
   logic [KW-1:0]  k_init;

   assign key_full = (count_ff == KCW'(KEY_DEPTH));
   assign k_we     = cmd.key_wr && !key_full;

   assign ptr_nx  = (ptr_ff == TAW'(STATE_WORDS - 1)) ? '0 : ptr_ff + TAW'(1);
   assign ptr_far = (ptr_ff < TAW'(STATE_WORDS - TWIST_OFFSET)) ?
                    ptr_ff + TAW'(TWIST_OFFSET) : ptr_ff - TAW'(STATE_WORDS - TWIST_OFFSET);

   assign mult_src  = prev_ff ^ (prev_ff >> 30);
   assign fill_word = prod_ff + 32'(idx_ff);
   assign mix_base  = t_rdata ^ prod_ff;
   assign mix_word  = pass2_ff ? (mix_base - 32'(idx_ff))
                               : (mix_base + k_rdata + 32'(j_ff));
   assign y          = {cur_ff[31], nxt_ff[30:0]};
   assign twist_word = t_rdata ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);

   assign j_inc  = KCW'(j_ff) + KCW'(1);
   assign k_init = (KW'(len_ff) > KW'(STATE_WORDS)) ? KW'(len_ff) : KW'(STATE_WORDS);

   always_comb begin
      t_we    = 1'b1;
      t_waddr = '0;
      t_wdata = 32'd0;
      priority if (cmd.seed_val) begin
         t_wdata = value;
      end else if (cmd.seed_key) begin
         t_wdata = ARRAY_SEED;
      end else if (cmd.fill_wr) begin
         t_waddr = idx_ff;
         t_wdata = fill_word;
      end else if (cmd.mix_wr) begin
         t_waddr = idx_ff;
         t_wdata = mix_word;
      end else if (cmd.wrap_wr) begin
         t_wdata = prev_ff;
      end else if (cmd.final_wr) begin
         t_wdata = HIGH_BIT;
      end else if (cmd.nxt_d) begin
         t_waddr = ptr_ff;
         t_wdata = twist_word;
      end else begin
         t_we = 1'b0;
      end
   end

   always_comb begin
      priority if (cmd.mix_rd) begin
         t_raddr = idx_ff;
      end else if (cmd.nxt_b) begin
         t_raddr = ptr_nx;
      end else if (cmd.nxt_c) begin
         t_raddr = ptr_far;
      end else begin
         t_raddr = ptr_ff;
      end
   end

   mtg_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_table (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   mtg_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_keys (
      .clock   (clock),
      .wr_en   (k_we),
      .wr_addr (count_ff[KAW-1:0]),
      .wr_data (value),
      .rd_addr (j_ff),
      .rd_data (k_rdata)
   );

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.seed_val) begin
         prev_ff <= value;
      end else if (cmd.seed_key) begin
         prev_ff <= ARRAY_SEED;
      end else if (cmd.fill_wr) begin
         prev_ff <= (stat.fill_last && keys_ff) ? ARRAY_SEED : fill_word;
      end else if (cmd.mix_wr) begin
         prev_ff <= mix_word;
      end
      if (cmd.fill_mul) begin
         prod_ff <= mult_src * SEED_MULT;
      end else if (cmd.mix_rd) begin
         prod_ff <= mult_src * (pass2_ff ? MIX2_MULT : MIX1_MULT);
      end
      if (cmd.nxt_b) begin
         cur_ff <= t_rdata;
      end
      if (cmd.nxt_c) begin
         nxt_ff <= t_rdata;
      end
      if (cmd.nxt_d) begin
         word_ff <= temper(twist_word);
         flag_ff <= 1'b0;
      end else if (cmd.noseed) begin
         word_ff <= 32'd0;
         flag_ff <= 1'b1;
      end
   end

   // counters and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         ptr_ff    <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
         len_ff    <= '0;
         count_ff  <= '0;
         pass2_ff  <= 1'b0;
         done_ff   <= 1'b0;
         keys_ff   <= 1'b0;
         seeded_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= cmd.nxt_d || cmd.noseed;
         if (cmd.seed_val || cmd.seed_key) begin
            idx_ff  <= TAW'(1);
            keys_ff <= cmd.seed_key;
         end
         if (k_we) begin
            count_ff <= count_ff + KCW'(1);
         end
         if (cmd.seed_key) begin
            len_ff <= key_full ? count_ff : count_ff + KCW'(1);
         end
         if (cmd.fill_wr) begin
            if (stat.fill_last) begin
               if (keys_ff) begin
                  idx_ff   <= TAW'(1);
                  j_ff     <= '0;
                  k_ff     <= k_init;
                  pass2_ff <= 1'b0;
                  done_ff  <= 1'b0;
               end else begin
                  seeded_ff <= 1'b1;
                  ptr_ff    <= '0;
               end
            end else begin
               idx_ff <= idx_ff + TAW'(1);
            end
         end
         if (cmd.mix_wr) begin
            idx_ff <= stat.i_last ? TAW'(1) : idx_ff + TAW'(1);
            j_ff   <= (j_inc >= len_ff) ? '0 : j_inc[KAW-1:0];
            if (stat.k_last) begin
               if (pass2_ff) begin
                  done_ff <= 1'b1;
               end else begin
                  pass2_ff <= 1'b1;
                  k_ff     <= KW'(STATE_WORDS - 1);
               end
            end else begin
               k_ff <= k_ff - KW'(1);
            end
         end
         if (cmd.final_wr) begin
            seeded_ff <= 1'b1;
            ptr_ff    <= '0;
            count_ff  <= '0;
         end
         if (cmd.nxt_d) begin
            ptr_ff <= ptr_nx;
         end
      end
   end

   assign stat.seeded    = seeded_ff;
   assign stat.fill_last = (idx_ff == TAW'(STATE_WORDS - 1));
   assign stat.mix_keys  = keys_ff;
   assign stat.i_last    = (idx_ff == TAW'(STATE_WORDS - 1));
   assign stat.k_last    = (k_ff == KW'(1));
   assign stat.pass2     = pass2_ff;
   assign stat.mix_done  = done_ff;

   assign rsp_valid       = valid_ff;
   assign rsp_random_word = word_ff;
   assign rsp_not_seeded  = flag_ff;
endmodule

// ----- hdl/mt19937_generator.sv -----
// Next word: busy for 4 table-port steps (three reads, one write), strobe registered after the write.
// Next before seeding: strobe on the cycle after accept. Key word alone: stored without leaving idle.
// Seed word: busy through the fill recurrence, alternating multiply and write steps for table words 1 to 623.
// Last key word: fill, then a read and a write step per mix step over max(L,624)+623 steps plus wraps.
// Synchronous active-high reset clears control state; table and key store stay undefined.
module mt19937_generator
   import mtg_pkg::*;
#(
   parameter int KEY_DEPTH = KEY_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_value,
   input  logic        req_last_key,
   output logic        rsp_valid,
   output logic [31:0] rsp_random_word,
   output logic        rsp_not_seeded
);
   cmd_type    cmd;
   status_type stat;

   mtg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .op       (req_op),
      .last_key (req_last_key),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   mtg_datapath #(.KEY_DEPTH(KEY_DEPTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .value           (req_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_random_word (rsp_random_word),
      .rsp_not_seeded  (rsp_not_seeded)
   );
endmodule

// ----- bench/tb_mt19937_generator.sv -----
// Self-checking bench for the MT19937 generator: queued command driver, result monitor.
`timescale 1ns / 100ps
module tb_mt19937_generator;
   import mtg_pkg::*;

   typedef struct {
      logic [31:0] word;
      logic        unseeded;
   } draw_type;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] value;
      logic        last;
   } cmd_item_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_op;
   logic [31:0] req_value;
   logic        req_last_key;
   logic        rsp_valid;
   logic [31:0] rsp_random_word;
   logic        rsp_not_seeded;

   cmd_item_type pending_cmds[$];
   draw_type     expected_draws[$];
   int           offered_cnt = 0;
   int           taken_cnt   = 0;
   int           total_cmds  = 0;
   int           error_cnt   = 0;
   int           idle_pct[4] = '{0, 80, 0, 27};

   // shadow generator state
   logic [31:0] shadow_table[STATE_WORDS];
   logic [31:0] shadow_keys[KEY_DEPTH_DEFAULT];
   int          shadow_pos;
   int          shadow_key_cnt;
   bit          shadow_seeded;

   mt19937_generator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_value(req_value), .req_last_key(req_last_key),
      .rsp_valid(rsp_valid), .rsp_random_word(rsp_random_word),
      .rsp_not_seeded(rsp_not_seeded)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] shape_word(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & 32'h9d2c_5680);
      y = y ^ ((y << 15) & 32'hefc6_0000);
      return y ^ (y >> 18);
   endfunction

   function automatic void seed_table(input logic [31:0] s);
      logic [31:0] p;
      shadow_table[0] = s;
      for (int n = 1; n < STATE_WORDS; n++) begin
         p = shadow_table[n-1];
         shadow_table[n] = SEED_MULT * (p ^ (p >> 30)) + 32'(n);
      end
      shadow_pos = STATE_WORDS;
   endfunction

   function automatic void mix_keys(input int len);
      int i;
      int j;
      int k;
      logic [31:0] p;
      i = 1;
      j = 0;
      seed_table(ARRAY_SEED);
      k = (len > STATE_WORDS) ? len : STATE_WORDS;
      for (; k != 0; k--) begin
         p = shadow_table[i-1];
         shadow_table[i] = (shadow_table[i] ^ ((p ^ (p >> 30)) * MIX1_MULT))
                           + shadow_keys[j] + 32'(j);
         i++;
         j++;
         if (i >= STATE_WORDS) begin
            shadow_table[0] = shadow_table[STATE_WORDS-1];
            i = 1;
         end
         if (j >= len) j = 0;
      end
      for (k = STATE_WORDS - 1; k != 0; k--) begin
         p = shadow_table[i-1];
         shadow_table[i] = (shadow_table[i] ^ ((p ^ (p >> 30)) * MIX2_MULT)) - 32'(i);
         i++;
         if (i >= STATE_WORDS) begin
            shadow_table[0] = shadow_table[STATE_WORDS-1];
            i = 1;
         end
      end
      shadow_table[0] = HIGH_BIT;
      shadow_pos = STATE_WORDS;
   endfunction

   function automatic void twist_table();
      logic [31:0] y;
      for (int n = 0; n < STATE_WORDS; n++) begin
         y = (shadow_table[n] & HIGH_BIT) |
             (shadow_table[(n + 1) % STATE_WORDS] & ~HIGH_BIT);
         shadow_table[n] = shadow_table[(n + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1) ^
                           (y[0] ? TWIST_MATRIX : 32'h0);
      end
      shadow_pos = 0;
   endfunction

   function automatic void predict_draw(input logic [1:0] op, input logic [31:0] value,
                                        input logic last);
      draw_type d;
      case (op)
         OP_SEED: begin
            seed_table(value);
            shadow_seeded = 1'b1;
         end
         OP_KEY: begin
            if (shadow_key_cnt < KEY_DEPTH_DEFAULT) begin
               shadow_keys[shadow_key_cnt] = value;
               shadow_key_cnt++;
            end
            if (last) begin
               mix_keys(shadow_key_cnt);
               shadow_key_cnt = 0;
               shadow_seeded = 1'b1;
            end
         end
         OP_NEXT: begin
            if (!shadow_seeded) begin
               d.word = 32'h0;
               d.unseeded = 1'b1;
            end else begin
               if (shadow_pos >= STATE_WORDS) twist_table();
               d.word = shape_word(shadow_table[shadow_pos]);
               d.unseeded = 1'b0;
               shadow_pos++;
            end
            expected_draws.push_back(d);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      error_cnt++;
   endtask

   task automatic queue_cmd(input logic [1:0] op, input logic [31:0] value,
                            input logic last);
      cmd_item_type c;
      c.op = op;
      c.value = value;
      c.last = last;
      pending_cmds.push_back(c);
      total_cmds++;
   endtask

   // driver: present items at the falling edge, hold until taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!(start && taken_cnt != offered_cnt)) begin
            if (pending_cmds.size() > 0 &&
                $urandom_range(99) >= idle_pct[(offered_cnt / 200) % 4]) begin
               cmd_item_type c;
               c = pending_cmds.pop_front();
               req_op <= c.op;
               req_value <= c.value;
               req_last_key <= c.last;
               start <= 1'b1;
               offered_cnt++;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // accept and monitor at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            taken_cnt++;
            predict_draw(req_op, req_value, req_last_key);
         end
         if (rsp_valid) begin
            if (expected_draws.size() == 0) begin
               report_mismatch("unexpected result", rsp_random_word, 32'h0);
            end else begin
               draw_type d;
               d = expected_draws.pop_front();
               if (rsp_random_word !== d.word)
                  report_mismatch("random_word", rsp_random_word, d.word);
               if (rsp_not_seeded !== d.unseeded)
                  report_mismatch("not_seeded", 32'(rsp_not_seeded), 32'(d.unseeded));
            end
         end
      end
   end

   initial begin
      int r;
      int len;
      bit long_done;
      start = 1'b0;
      req_op = OP_NEXT;
      req_value = 32'h0;
      req_last_key = 1'b0;
      shadow_pos = STATE_WORDS;
      shadow_key_cnt = 0;
      shadow_seeded = 1'b0;
      long_done = 1'b0;
      reset = 1'b1;

      // next before seeding, unused op, seeds and short keys at the extremes
      queue_cmd(OP_NEXT, 32'h1234_5678, 1'b0);
      queue_cmd(OP_NEXT, 32'hffff_ffff, 1'b1);
      queue_cmd(2'd3, 32'hffff_ffff, 1'b1);
      queue_cmd(OP_SEED, 32'h0, 1'b0);
      repeat (3) queue_cmd(OP_NEXT, 32'h0, 1'b0);
      queue_cmd(OP_SEED, 32'hffff_ffff, 1'b1);
      queue_cmd(OP_NEXT, 32'h0, 1'b1);
      queue_cmd(OP_KEY, 32'h0000_0123, 1'b0);
      queue_cmd(OP_KEY, 32'h0000_0234, 1'b0);
      queue_cmd(OP_KEY, 32'h0000_0345, 1'b0);
      queue_cmd(OP_KEY, 32'h0000_0456, 1'b1);
      queue_cmd(OP_NEXT, 32'h0, 1'b0);
      queue_cmd(OP_NEXT, 32'h0, 1'b0);
      queue_cmd(OP_KEY, 32'hffff_ffff, 1'b1);
      queue_cmd(OP_NEXT, 32'h0, 1'b0);
      queue_cmd(OP_SEED, 32'd5489, 1'b0);
      queue_cmd(OP_NEXT, 32'h0, 1'b0);
      queue_cmd(2'd3, 32'h0, 1'b0);
      queue_cmd(OP_NEXT, 32'h0, 1'b0);

      while (total_cmds < 1550) begin
         r = $urandom_range(99);
         if (!long_done && total_cmds > 600) begin
            // overflow the key store; extra words drop
            for (int n = 0; n < KEY_DEPTH_DEFAULT + 6; n++) queue_cmd(OP_KEY, $urandom, 1'b0);
            queue_cmd(OP_KEY, $urandom, 1'b1);
            long_done = 1'b1;
         end else if (r < 82) begin
            queue_cmd(OP_NEXT, $urandom, 1'($urandom));
         end else if (r < 85) begin
            queue_cmd(OP_SEED, $urandom, 1'($urandom));
         end else if (r < 93) begin
            len = $urandom_range(8, 1);
            for (int n = 1; n < len; n++) queue_cmd(OP_KEY, $urandom, 1'b0);
            queue_cmd(OP_KEY, $urandom, 1'b1);
         end else if (r < 97) begin
            queue_cmd(2'd3, $urandom, 1'($urandom));
         end else begin
            // stray key word without a last mark
            queue_cmd(OP_KEY, $urandom, 1'b0);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (pending_cmds.size() == 0 && taken_cnt == total_cmds);
      wait (expected_draws.size() == 0);
      @(posedge clock);
      while (busy) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_cnt == 0 && expected_draws.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end
endmodule
